// ===== rtl/sine_tone_generator_macros.svh =====
// Assertion macros used by the sine tone generator sequencer (stg_ctrl).
// Assertions are left out when SYNTH is defined.
`ifndef SINE_TONE_GENERATOR_MACROS_SVH
`define SINE_TONE_GENERATOR_MACROS_SVH
`ifndef SYNTH
`define STG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sine_tone_generator: assertion failed");
`define STG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sine_tone_generator: assertion failed");
`else
`define STG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define STG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/stg_pkg.sv =====
package stg_pkg;

   localparam int TABLE_BITS = 10;
   localparam int PHASE_BITS = 32;
   localparam int QTR_BITS   = TABLE_BITS - 2;
   localparam int QTR_SIZE   = 1 << QTR_BITS;
   localparam int Q15_BITS   = 15;

   localparam int STEP_BITS  = 32;
   localparam int VOL_BITS   = 7;
   localparam int COUNT_BITS = 24;
   localparam int CSR_BITS   = 32;

   localparam logic [STEP_BITS-1:0]  STEP_RESET  = 32'd42852281;
   localparam logic [VOL_BITS-1:0]   VOL_RESET   = 7'd100;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 24'd44100;

   // register indexes on the csr port
   localparam logic [1:0] CSR_PHASE_STEP     = 2'd0;
   localparam logic [1:0] CSR_VOLUME_PERCENT = 2'd1;
   localparam logic [1:0] CSR_PRODUCT_MODE   = 2'd2;
   localparam logic [1:0] CSR_SAMPLE_COUNT   = 2'd3;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned Q15_MAX     = 64'd32767;
   // (2n)(2n+1) for the Taylor terms, index 0 unused
   localparam longint unsigned TAYLOR_DIV [8] = '{64'd1, 64'd6, 64'd20, 64'd42,
                                                 64'd72, 64'd110, 64'd156, 64'd210};

   typedef logic [Q15_BITS-1:0] qtr_tab_type [QTR_SIZE+1];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAB,
      ST_MUL1,
      ST_MUL2,
      ST_SCALE,
      ST_OUT
   } stg_state_type;

   typedef struct packed {
      logic start;     // latch item, advance phase/index
      logic tab;       // table lookup
      logic mul1;      // sin*cos or sin
      logic mul2;      // times volume
      logic scale;     // divide, offset, saturate
      logic load_out;  // move result to the output register
   } stg_cmd_type;

   // Q15 sine of k quarter-table steps, 8-term Taylor series in Q30
   function automatic logic [Q15_BITS-1:0] sine_q15_of(logic [QTR_BITS:0] k);
      longint unsigned x;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned r;
      x    = (64'(k) * HALF_PI_Q30) / QTR_SIZE;
      term = x;
      sum  = x;
      for (int n = 1; n < 8; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / TAYLOR_DIV[n[2:0]];
         if (n[0]) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
      return (r > Q15_MAX) ? Q15_BITS'(Q15_MAX) : Q15_BITS'(r);
   endfunction

   function automatic qtr_tab_type build_qtr_tab();
      qtr_tab_type t;
      for (logic [QTR_BITS+1:0] k = '0; k <= (QTR_BITS+2)'(QTR_SIZE); k++) begin
         t[k[QTR_BITS:0]] = sine_q15_of(k[QTR_BITS:0]);
      end
      return t;
   endfunction

   localparam qtr_tab_type QTR_TAB = build_qtr_tab();

   // magnitude of the sine at a full-circle table index
   function automatic logic [Q15_BITS-1:0] wave_mag(logic [TABLE_BITS-1:0] idx);
      logic [QTR_BITS:0] off;
      off = {1'b0, idx[QTR_BITS-1:0]};
      if (idx[QTR_BITS]) begin
         return QTR_TAB[(QTR_BITS+1)'(QTR_SIZE) - off];
      end
      return QTR_TAB[off];
   endfunction

endpackage

// ===== rtl/stg_ctrl.sv =====
`include "sine_tone_generator_macros.svh"

module stg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output stg_pkg::stg_cmd_type cmd
);

   stg_pkg::stg_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         stg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = stg_pkg::ST_TAB;
            end
         end
         stg_pkg::ST_TAB: begin
            cmd.tab  = 1'b1;
            state_in = stg_pkg::ST_MUL1;
         end
         stg_pkg::ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = stg_pkg::ST_MUL2;
         end
         stg_pkg::ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = stg_pkg::ST_SCALE;
         end
         stg_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = stg_pkg::ST_OUT;
         end
         stg_pkg::ST_OUT: begin
            // wait for the output register to drain
            if (slot_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = stg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stg_pkg::ST_IDLE;
         end
      endcase
   end

   `STG_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready,
                    state_ff == stg_pkg::ST_TAB)
   `STG_ASSERT_IMPL(a_load_into_free_slot, clock, reset, cmd.load_out,
                    !rsp_valid_ff || rsp_tready)
   `STG_ASSERT_NEXT(a_scale_then_out, clock, reset, state_ff == stg_pkg::ST_SCALE,
                    state_ff == stg_pkg::ST_OUT)
   `STG_ASSERT_IMPL(a_drop_only_when_taken, clock, reset, $fell(rsp_valid_ff),
                    $past(rsp_tready))

endmodule

// ===== rtl/stg_dp.sv =====
module stg_dp (
   input  logic                clock,
   input  logic                reset,
   input  stg_pkg::stg_cmd_type cmd,
   input  logic                restart,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [stg_pkg::CSR_BITS-1:0] csr_wdata,
   output logic [7:0]          rsp_sample,
   output logic                rsp_last
);

   // configuration
   logic [stg_pkg::STEP_BITS-1:0]  step_ff;
   logic [stg_pkg::VOL_BITS-1:0]   vol_ff;
   logic                           mode_ff;
   logic [stg_pkg::COUNT_BITS-1:0] count_ff;

   // tone state
   logic [stg_pkg::PHASE_BITS-1:0] phase_ff, phase_in;
   logic [stg_pkg::COUNT_BITS-1:0] index_ff, index_in;
   logic [stg_pkg::PHASE_BITS-1:0] eff_phase;
   logic [stg_pkg::COUNT_BITS-1:0] eff_index;
   logic                           last_now;

   // per-item pipeline registers
   logic [stg_pkg::TABLE_BITS-1:0] idx_ff;
   logic                           last_ff;
   logic [stg_pkg::TABLE_BITS-1:0] cos_idx;
   logic [stg_pkg::Q15_BITS-1:0]   s_mag_ff, c_mag_ff;
   logic                           s_neg_ff, c_neg_ff;
   logic [2*stg_pkg::Q15_BITS-1:0] p1_ff;
   logic                           neg_ff;
   logic [2*stg_pkg::Q15_BITS+stg_pkg::VOL_BITS-1:0] p2_ff;
   logic [21:0]                    mag_scaled;
   logic [11:0]                    mag_div;
   logic [22:0]                    recip_prod;
   logic [7:0]                     quot;
   logic signed [9:0]              val;
   logic [7:0]                     smp_ff, smp_in;
   logic [7:0]                     rsp_sample_ff;
   logic                           rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= stg_pkg::STEP_RESET;
         vol_ff   <= stg_pkg::VOL_RESET;
         mode_ff  <= 1'b0;
         count_ff <= stg_pkg::COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            stg_pkg::CSR_PHASE_STEP:     step_ff  <= csr_wdata[stg_pkg::STEP_BITS-1:0];
            stg_pkg::CSR_VOLUME_PERCENT: vol_ff   <= csr_wdata[stg_pkg::VOL_BITS-1:0];
            stg_pkg::CSR_PRODUCT_MODE:   mode_ff  <= csr_wdata[0];
            stg_pkg::CSR_SAMPLE_COUNT:   count_ff <= csr_wdata[stg_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // restart acts before the sample; end of tone wraps both to zero
   always_comb begin
      eff_phase = restart ? '0 : phase_ff;
      eff_index = restart ? '0 : index_ff;
      last_now  = ({1'b0, eff_index} + 25'd1) >= {1'b0, count_ff};
      phase_in  = last_now ? '0 : eff_phase + stg_pkg::PHASE_BITS'(step_ff);
      index_in  = last_now ? '0 : eff_index + 24'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         index_ff <= '0;
      end else if (cmd.start) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff  <= eff_phase[stg_pkg::PHASE_BITS-1 -: stg_pkg::TABLE_BITS];
         last_ff <= last_now;
      end
   end

   // cosine is the same table a quarter turn ahead
   assign cos_idx = idx_ff + stg_pkg::TABLE_BITS'(stg_pkg::QTR_SIZE);

   always_ff @(posedge clock) begin
      if (cmd.tab) begin
         s_mag_ff <= stg_pkg::wave_mag(idx_ff);
         s_neg_ff <= idx_ff[stg_pkg::TABLE_BITS-1];
         c_mag_ff <= stg_pkg::wave_mag(cos_idx);
         c_neg_ff <= cos_idx[stg_pkg::TABLE_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         p1_ff  <= mode_ff ? s_mag_ff * c_mag_ff
                           : {{stg_pkg::Q15_BITS{1'b0}}, s_mag_ff};
         neg_ff <= mode_ff ? (s_neg_ff ^ c_neg_ff) : s_neg_ff;
      end
      if (cmd.mul2) begin
         p2_ff <= p1_ff * vol_ff;
      end
   end

   // |v| / (100 * 2^8) after dropping the extra Q15 of the product:
   // drop 10 bits, then /25 as *1311 >> 15 (exact for 12-bit values)
   always_comb begin
      mag_scaled = mode_ff ? p2_ff[36:15] : p2_ff[21:0];
      mag_div    = mag_scaled[21:10];
      recip_prod = mag_div * 11'd1311;
      quot       = recip_prod[22:15];
      val        = neg_ff ? 10'sd128 - $signed({2'b00, quot})
                          : 10'sd128 + $signed({2'b00, quot});
      if (val < 10'sd0) begin
         smp_in = 8'd0;
      end else if (val > 10'sd255) begin
         smp_in = 8'd255;
      end else begin
         smp_in = val[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         smp_ff <= smp_in;
      end
      if (cmd.load_out) begin
         rsp_sample_ff <= smp_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== rtl/sine_tone_generator.sv =====
// DDS sine tone generator, 8-bit offset-binary PCM.
// req_ channel: one word per sample tick; req_tdata[0] is restart, which
//   zeroes phase and sample index before this sample.
// rsp_ channel: one word per tick; rsp_tdata is the sample (128 = silence),
//   rsp_tlast marks the final sample of the configured tone length, after
//   which phase and index wrap to zero and the tone repeats.
// csr_ port: csr_we with csr_index 0 phase_step, 1 volume_percent,
//   2 product_mode, 3 sample_count; write only while no word is in flight.
// The sequencer steps through accept, table read, two multiplies, scale and
//   output; rsp_tvalid rises as the output step loads the output register.
//   A new req word is taken only in the idle step, once the last word is loaded.
// The output register holds a finished word, so the next req word is taken
//   while the receiver stalls; the sequencer then waits in its last step
//   until rsp_tready frees the register. Nothing is dropped or repeated.
// Reset: synchronous, clears phase and index, restores register defaults
//   (step 42852281, volume 100, plain mode, 44100 samples), drops rsp_tvalid.
module sine_tone_generator (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] sample
   output logic        rsp_tlast,   // last sample of the tone
   // register write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [stg_pkg::CSR_BITS-1:0] csr_wdata
);

   stg_pkg::stg_cmd_type cmd;

   // sequencer: handshakes and step commands
   stg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // phase accumulator, table, multipliers and output register
   stg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .restart    (req_tdata[0]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_sample (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule
